// ----- design/bfgr_pkg.sv -----
`default_nettype none

package bfgr_pkg;

  // Default sizes
  localparam int FONT_BYTES_DEF  = 2048;
  localparam int MAX_COLUMNS_DEF = 32;

  // Input item modes
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_ADDR   = 2'd1;
  localparam logic [1:0] MODE_RENDER = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CMD     = 2'd1;
  localparam logic [1:0] KIND_MISSING = 2'd2;

  // Display controller address commands
  localparam logic [7:0] CMD_PAGE   = 8'h40;
  localparam logic [7:0] CMD_COLUMN = 8'h80;

  // Pixel rows held by one display byte
  localparam int BYTE_ROWS = 8;

  // Font read address select
  localparam logic [2:0] ASEL_HDR_COUNT = 3'd0;
  localparam logic [2:0] ASEL_HDR_ROWS  = 3'd1;
  localparam logic [2:0] ASEL_CODE      = 3'd2;
  localparam logic [2:0] ASEL_WIDTH     = 3'd3;
  localparam logic [2:0] ASEL_COL0      = 3'd4;
  localparam logic [2:0] ASEL_COL1      = 3'd5;

  // Output byte select
  localparam logic [1:0] OSEL_DATA    = 2'd0;
  localparam logic [1:0] OSEL_PAGE    = 2'd1;
  localparam logic [1:0] OSEL_COLUMN  = 2'd2;
  localparam logic [1:0] OSEL_MISSING = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       take_item;
    logic       wr_en;
    logic       rd_en;
    logic [2:0] asel;
    logic       count_ld;
    logic       rows_ld;
    logic       walk_init;
    logic       code_ld;
    logic       walk_adv;
    logic       cols_ld;
    logic       c0_ld;
    logic       c1_ld;
    logic       col_adv;
    logic       out_ld;
    logic [1:0] osel;
    logic       out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_end;
    logic match;
    logic cols_zero;
    logic col_last;
    logic tall;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/bfgr_ram.sv -----
`default_nettype none

module bfgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/bfgr_datapath.sv -----
`default_nettype none

module bfgr_datapath #(
  parameter int FONT_BYTES  = bfgr_pkg::FONT_BYTES_DEF,
  parameter int MAX_COLUMNS = bfgr_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bfgr_pkg::dp_cmd_t cmd,
  output bfgr_pkg::dp_sts_t      sts,
  input  wire logic [10:0]       font_address,
  input  wire logic [7:0]        font_byte,
  input  wire logic [7:0]        char_code,
  input  wire logic [6:0]        column_x,
  input  wire logic [2:0]        bank,
  input  wire logic [2:0]        row_shift,
  input  wire logic              lower_half,
  input  wire logic              invert,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             kind,
  output logic [7:0]             out_byte,
  output logic                   last
);

  import bfgr_pkg::*;

  localparam int AW = $clog2(FONT_BYTES);
  localparam int RW = AW + 2;
  localparam int CW = $clog2(MAX_COLUMNS + 1);

  // Item fields held for the whole render
  logic [7:0]    key_code;
  logic [6:0]    col_pos;
  logic [2:0]    bank_sel;
  logic [2:0]    shift;
  logic          lower;
  logic          inv;

  // Walk and column state
  logic [7:0]    count;
  logic          tall;
  logic [RW-1:0] rec;
  logic [7:0]    idx;
  logic          matched;
  logic [CW-1:0] ncols;
  logic [CW-1:0] ncol;
  logic [7:0]    c0;
  logic [7:0]    c1;
  logic          rd_oob;

  logic [RW-1:0] rd_addr;
  logic [RW-1:0] col_off;
  logic          rd_in_range;
  logic          wr_ok;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_q;
  logic [7:0]    rd_data;
  logic [7:0]    wcols;
  logic [CW-1:0] ncols_next;
  logic [15:0]   sh0;
  logic [15:0]   sh1;
  logic [7:0]    data_byte;
  logic [7:0]    byte_sel;
  logic [1:0]    kind_sel;

  // Font read address
  assign col_off = tall ? RW'({ncol, 1'b0}) : RW'(ncol);

  always_comb begin
    case (cmd.asel)
      ASEL_HDR_COUNT: rd_addr = '0;
      ASEL_HDR_ROWS:  rd_addr = RW'(1);
      ASEL_CODE:      rd_addr = rec;
      ASEL_WIDTH:     rd_addr = rec + RW'(1);
      ASEL_COL0:      rd_addr = rec + RW'(2) + col_off;
      ASEL_COL1:      rd_addr = rec + RW'(3) + col_off;
      default:        rd_addr = '0;
    endcase
  end

  assign rd_in_range = rd_addr < RW'(FONT_BYTES);
  assign wr_ok       = 32'(font_address) < 32'(FONT_BYTES);
  assign ram_addr    = cmd.wr_en ? AW'(font_address) : rd_addr[AW-1:0];

  bfgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk   (clk),
    .we    (cmd.wr_en && wr_ok),
    .re    (cmd.rd_en && rd_in_range),
    .addr  (ram_addr),
    .wdata (font_byte),
    .rdata (ram_q)
  );

  // Reads past the end of the store give zero
  assign rd_data = rd_oob ? 8'h00 : ram_q;

  // Column count, halved for tall fonts, clamped
  assign wcols      = tall ? {1'b0, rd_data[7:1]} : rd_data;
  assign ncols_next = (wcols > 8'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(wcols);

  // Shifted column bytes: upper pass is the low byte, spill is the high byte
  assign sh0 = {8'h00, c0} << shift;
  assign sh1 = {8'h00, c1} << shift;

  always_comb begin
    if (tall) begin
      data_byte = lower ? (sh0[15:8] | sh1[7:0]) : sh0[7:0];
    end else begin
      data_byte = lower ? sh0[15:8] : sh0[7:0];
      if (inv) begin
        data_byte = ~data_byte;
      end
    end
  end

  always_comb begin
    case (cmd.osel)
      OSEL_DATA: begin
        byte_sel = data_byte;
        kind_sel = KIND_DATA;
      end
      OSEL_PAGE: begin
        byte_sel = CMD_PAGE + {5'b0, bank_sel};
        kind_sel = KIND_CMD;
      end
      OSEL_COLUMN: begin
        byte_sel = CMD_COLUMN + {1'b0, col_pos};
        kind_sel = KIND_CMD;
      end
      default: begin
        byte_sel = 8'h00;
        kind_sel = KIND_MISSING;
      end
    endcase
  end

  // Status
  assign sts.walk_end  = (idx == count) || (rec >= RW'(FONT_BYTES));
  assign sts.match     = matched;
  assign sts.cols_zero = (wcols == 8'h00);
  assign sts.col_last  = (ncol == ncols - CW'(1));
  assign sts.tall      = tall;
  assign sts.out_free  = !out_valid || !out_stall;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      key_code <= char_code;
      col_pos  <= column_x;
      bank_sel <= bank;
      shift    <= row_shift;
      lower    <= lower_half;
      inv      <= invert;
    end
    if (cmd.rd_en) begin
      rd_oob <= !rd_in_range;
    end
    if (cmd.count_ld) begin
      count <= rd_data;
    end
    if (cmd.rows_ld) begin
      tall <= rd_data > 8'(BYTE_ROWS);
    end
    if (cmd.walk_init) begin
      rec <= RW'(2);
      idx <= '0;
    end else if (cmd.walk_adv) begin
      rec <= rec + RW'(rd_data) + RW'(2);
      idx <= idx + 8'd1;
    end
    if (cmd.code_ld) begin
      matched <= (rd_data == key_code);
    end
    if (cmd.cols_ld) begin
      ncols <= ncols_next;
      ncol  <= '0;
    end else if (cmd.col_adv) begin
      ncol <= ncol + CW'(1);
    end
    if (cmd.c0_ld) begin
      c0 <= rd_data;
    end
    if (cmd.c1_ld) begin
      c1 <= rd_data;
    end
    if (cmd.out_ld) begin
      kind     <= kind_sel;
      out_byte <= byte_sel;
      last     <= cmd.out_last;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/bfgr_ctrl.sv -----
`default_nettype none

module bfgr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        mode,
  input  wire bfgr_pkg::dp_sts_t sts,
  output bfgr_pkg::dp_cmd_t      cmd
);

  import bfgr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HDR0 = 4'd1;
  localparam logic [3:0] S_HDR1 = 4'd2;
  localparam logic [3:0] S_HDR2 = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_CODE = 4'd5;
  localparam logic [3:0] S_WID  = 4'd6;
  localparam logic [3:0] S_COL  = 4'd7;
  localparam logic [3:0] S_C0   = 4'd8;
  localparam logic [3:0] S_C1   = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;
  localparam logic [3:0] S_MISS = 4'd11;
  localparam logic [3:0] S_CMD0 = 4'd12;
  localparam logic [3:0] S_CMD1 = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          case (mode)
            MODE_WRITE:  cmd.wr_en = 1'b1;
            MODE_ADDR:   state_next = S_CMD0;
            MODE_RENDER: state_next = S_HDR0;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      // Header: glyph count then row height
      S_HDR0: begin
        cmd.rd_en  = 1'b1;
        cmd.asel   = ASEL_HDR_COUNT;
        state_next = S_HDR1;
      end
      S_HDR1: begin
        cmd.rd_en    = 1'b1;
        cmd.asel     = ASEL_HDR_ROWS;
        cmd.count_ld = 1'b1;
        state_next   = S_HDR2;
      end
      S_HDR2: begin
        cmd.rows_ld   = 1'b1;
        cmd.walk_init = 1'b1;
        state_next    = S_CHK;
      end
      // Record walk: code read, width read, compare and skip
      S_CHK: begin
        if (sts.walk_end) begin
          state_next = S_MISS;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.asel   = ASEL_CODE;
          state_next = S_CODE;
        end
      end
      S_CODE: begin
        cmd.rd_en   = 1'b1;
        cmd.asel    = ASEL_WIDTH;
        cmd.code_ld = 1'b1;
        state_next  = S_WID;
      end
      S_WID: begin
        if (!sts.match) begin
          cmd.walk_adv = 1'b1;
          state_next   = S_CHK;
        end else if (sts.cols_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.cols_ld = 1'b1;
          state_next  = S_COL;
        end
      end
      // Column fetch, one or two bytes
      S_COL: begin
        cmd.rd_en  = 1'b1;
        cmd.asel   = ASEL_COL0;
        state_next = S_C0;
      end
      S_C0: begin
        cmd.c0_ld = 1'b1;
        if (sts.tall) begin
          cmd.rd_en  = 1'b1;
          cmd.asel   = ASEL_COL1;
          state_next = S_C1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_C1: begin
        cmd.c1_ld  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.osel     = OSEL_DATA;
          cmd.out_last = sts.col_last;
          if (sts.col_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.col_adv = 1'b1;
            state_next  = S_COL;
          end
        end
      end
      S_MISS: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.osel     = OSEL_MISSING;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // Display address command pair
      S_CMD0: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.osel   = OSEL_PAGE;
          state_next = S_CMD1;
        end
      end
      S_CMD1: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.osel     = OSEL_COLUMN;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/bitmap_font_glyph_renderer.sv -----
`default_nettype none

// Bitmap font glyph renderer.
// Input channel (in_valid/in_stall) takes one item: mode 0 writes a font byte
// into the internal font store, mode 1 asks for the two display address
// commands (page, then column), mode 2 renders one character, mode 3 is a no-op.
// Output channel (out_valid/out_stall) carries kind, out_byte and last; last
// marks the final result of an item.
// Font writes are done as the item is taken. Address commands: the item is taken,
// then each command byte is loaded in turn.
// Render: header reads, then a code and a width read per font record scanned,
// then one column byte read per column (two for fonts taller than 8 rows), all
// through the single port of the font store. A missing glyph gives one marker result.
// The block works on one item at a time; in_stall is high until the item's
// last result has been loaded into the output register, which then waits on
// its own while the next item is taken.
// A stalled output holds its result and pauses the render.
// Reset (rst, synchronous) returns the controller to idle and drops out_valid;
// the font store keeps its contents and must be written before use.

module bitmap_font_glyph_renderer #(
  parameter int FONT_BYTES  = bfgr_pkg::FONT_BYTES_DEF,
  parameter int MAX_COLUMNS = bfgr_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [10:0] font_address,
  input  wire logic [7:0]  font_byte,
  input  wire logic [7:0]  char_code,
  input  wire logic [6:0]  column_x,
  input  wire logic [2:0]  bank,
  input  wire logic [2:0]  row_shift,
  input  wire logic        lower_half,
  input  wire logic        invert,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic             last
);

  import bfgr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfgr_datapath #(
    .FONT_BYTES  (FONT_BYTES),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .font_address (font_address),
    .font_byte    (font_byte),
    .char_code    (char_code),
    .column_x     (column_x),
    .bank         (bank),
    .row_shift    (row_shift),
    .lower_half   (lower_half),
    .invert       (invert),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .last         (last)
  );

`ifndef ASSERT_OFF
  // Missing glyph marker is a single zero byte closing the item
  a_missing_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_MISSING |-> last && out_byte == 8'h00)
    else $error("missing glyph marker malformed");

  // The first address command is always the page command
  a_page_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_CMD && !last |-> out_byte[7:3] == CMD_PAGE[7:3])
    else $error("page command byte malformed");

  // Render and address items keep the input side busy afterwards
  a_busy_after_render: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == MODE_RENDER || mode == MODE_ADDR) |=> in_stall)
    else $error("input taken while an item is in progress");
`endif

endmodule

`default_nettype wire
